### src/first_free_slot_allocator_defines.svh
// assertion macros for the first free slot allocator
`ifndef FIRST_FREE_SLOT_ALLOCATOR_DEFINES_SVH
`define FIRST_FREE_SLOT_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define FFA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ffa_pkg.sv
// shared types and constants of the first free slot allocator
package ffa_pkg;

  // default sizes
  localparam int unsigned SLOTS_DEF      = 64;
  localparam int unsigned OWNER_BITS_DEF = 16;

  // fixed field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned PID_W   = 16;
  localparam int unsigned SEAT_W  = 7;
  localparam int unsigned OWNER_W = 16;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned CFG_W   = 7;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_RESERVE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_QUERY   = 2'd2,
    OP_CLEAR   = 2'd3
  } ffa_op_e;

  // control word handed from cell to cell
  typedef struct packed {
    logic    valid;
    logic    live;
    ffa_op_e op;
    logic    found;
  } ffa_ctl_t;

endpackage

### src/ffa_req_if.sv
// request channel of the allocator
interface ffa_req_if;
  logic                      valid;
  logic                      ready;
  logic [ffa_pkg::OP_W-1:0]   operation;
  logic [ffa_pkg::PID_W-1:0]  person_id;
  logic [ffa_pkg::SEAT_W-1:0] seat_number;

  modport source (output valid, output operation, output person_id, output seat_number,
                  input ready);
  modport sink   (input valid, input operation, input person_id, input seat_number,
                  output ready);
endinterface

### src/ffa_rsp_if.sv
// response channel of the allocator
interface ffa_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       status;
  logic [ffa_pkg::CNT_W-1:0]   granted_seat;
  logic [ffa_pkg::OWNER_W-1:0] owner;
  logic [ffa_pkg::CNT_W-1:0]   free_count;
  logic [ffa_pkg::CNT_W-1:0]   occupied_count;

  modport source (output valid, output status, output granted_seat, output owner,
                  output free_count, output occupied_count, input ready);
  modport sink   (input valid, input status, input granted_seat, input owner,
                  input free_count, input occupied_count, output ready);
endinterface

### src/first_free_slot_allocator.sv
// top level of the first free slot allocator
// Each transaction enters an entry register and then walks a chain of SLOTS cells, one cell
// per cycle; cell k owns slot k+1. A reserve claims the first free in-capacity cell it meets,
// release and query act on the cell whose number matches, clear empties every cell on its
// way. The result is held in an output register behind the last cell, and the chain takes one new
// transaction every cycle, so the sustained rate is one per cycle; the whole chain stalls
// while a result waits to be taken. Counts are kept at the chain end, in order. Writing
// the capacity register empties the table at once; there is no clearing pass after reset.
`include "first_free_slot_allocator_defines.svh"
module first_free_slot_allocator #(
  parameter int unsigned SLOTS      = ffa_pkg::SLOTS_DEF,
  parameter int unsigned OWNER_BITS = ffa_pkg::OWNER_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ffa_pkg::CFG_W-1:0] cfg_wdata_i,
  ffa_req_if.sink                   req_i,
  ffa_rsp_if.source                 rsp_o
);
  import ffa_pkg::*;

  localparam int unsigned SL_W  = $clog2(SLOTS + 1);
  localparam int unsigned CAP_W = (SL_W > CFG_W) ? SL_W : CFG_W;

  // chain links, index 0 is the entry register
  ffa_ctl_t              ctl_s   [SLOTS+1];
  logic [OWNER_BITS-1:0] pid_s   [SLOTS+1];
  logic [SEAT_W-1:0]     seat_s  [SLOTS+1];
  logic [OWNER_BITS-1:0] who_s   [SLOTS+1];
  logic [CAP_W-1:0]      grant_s [SLOTS+1];

  logic [CFG_W-1:0]      cap_q;
  logic [CAP_W-1:0]      cap_eff;
  logic [CAP_W-1:0]      used_q, used_d;
  logic                  adv;
  ffa_ctl_t              ent_ctl_q, ent_ctl_d;
  logic [OWNER_BITS-1:0] ent_pid_q, pid_m;
  logic [SEAT_W-1:0]     ent_seat_q;
  logic                  seat_ok;
  ffa_ctl_t              last;
  logic                  out_valid_q;
  logic                  out_status_q;
  logic [CNT_W-1:0]      out_grant_q, out_free_q, out_occ_q;
  logic [OWNER_W-1:0]    out_owner_q;
  logic                  rsp_reject;
  logic                  rsp_blank;

  // effective capacity saturates at the table size
  assign cap_eff = (CAP_W'(cap_q) > CAP_W'(SLOTS)) ? CAP_W'(SLOTS) : CAP_W'(cap_q);

  // the chain moves whenever the output register can take its last stage
  assign adv         = !out_valid_q || rsp_o.ready;
  assign req_i.ready = adv;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= '0;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // entry checks
  always_comb begin
    pid_m     = OWNER_BITS'(req_i.person_id);
    seat_ok   = (req_i.seat_number != '0) && (CAP_W'(req_i.seat_number) <= cap_eff);
    ent_ctl_d.valid = req_i.valid;
    ent_ctl_d.op    = ffa_op_e'(req_i.operation);
    ent_ctl_d.live  = 1'b0;
    ent_ctl_d.found = 1'b0;
    if (cap_eff != '0) begin
      unique case (ffa_op_e'(req_i.operation))
        OP_RESERVE: ent_ctl_d.live = (pid_m != '0);
        OP_RELEASE: ent_ctl_d.live = seat_ok;
        OP_QUERY: begin
          ent_ctl_d.live  = seat_ok;
          ent_ctl_d.found = seat_ok;
        end
        OP_CLEAR: begin
          ent_ctl_d.live  = 1'b1;
          ent_ctl_d.found = 1'b1;
        end
        default: ent_ctl_d.live = 1'b0;
      endcase
    end
  end

  // entry register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_ctl_q <= '0;
    end else if (cfg_we_i) begin
      ent_ctl_q <= '0;
    end else if (adv) begin
      ent_ctl_q <= ent_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ent_pid_q  <= pid_m;
      ent_seat_q <= req_i.seat_number;
    end
  end

  assign ctl_s[0]   = ent_ctl_q;
  assign pid_s[0]   = ent_pid_q;
  assign seat_s[0]  = ent_seat_q;
  assign who_s[0]   = '0;
  assign grant_s[0] = '0;

  // row of slot cells
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    ffa_cell #(
      .IDX        (k),
      .OWNER_BITS (OWNER_BITS),
      .CAP_W      (CAP_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .clr_i   (cfg_we_i),
      .cap_i   (cap_eff),
      .ctl_i   (ctl_s[k]),
      .pid_i   (pid_s[k]),
      .seat_i  (seat_s[k]),
      .who_i   (who_s[k]),
      .grant_i (grant_s[k]),
      .ctl_o   (ctl_s[k+1]),
      .pid_o   (pid_s[k+1]),
      .seat_o  (seat_s[k+1]),
      .who_o   (who_s[k+1]),
      .grant_o (grant_s[k+1])
    );
  end

  assign last = ctl_s[SLOTS];

  // occupancy count at the chain end
  always_comb begin
    used_d = used_q;
    if (last.valid && last.live) begin
      unique case (last.op)
        OP_RESERVE: if (last.found) used_d = used_q + CAP_W'(1);
        OP_RELEASE: if (last.found) used_d = used_q - CAP_W'(1);
        OP_QUERY:   used_d = used_q;
        OP_CLEAR:   used_d = '0;
        default:    used_d = used_q;
      endcase
    end
  end

  // count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (cfg_we_i) begin
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      used_q      <= used_d;
      out_valid_q <= last.valid;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_status_q <= !(last.live && last.found);
      out_grant_q  <= CNT_W'(grant_s[SLOTS]);
      out_owner_q  <= OWNER_W'(who_s[SLOTS]);
      out_free_q   <= CNT_W'(cap_eff - used_d);
      out_occ_q    <= CNT_W'(used_d);
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.granted_seat   = out_grant_q;
  assign rsp_o.owner          = out_owner_q;
  assign rsp_o.free_count     = out_free_q;
  assign rsp_o.occupied_count = out_occ_q;

  // rejected result and empty data fields
  assign rsp_reject = out_valid_q && out_status_q;
  assign rsp_blank  = (out_grant_q == '0) && (out_owner_q == '0);

  // checks
  `FFA_ASSERT_IMP(a_used_in_cap, 1'b1, used_q <= cap_eff, "occupancy above capacity")
  `FFA_ASSERT_NXT(a_cfg_empties, cfg_we_i, used_q == '0, "capacity write left slots in use")
  `FFA_ASSERT_IMP(a_reject_clean, rsp_reject, rsp_blank, "rejected result carries data")

endmodule

### src/ffa_cell.sv
// one slot of the allocator chain: holds its owner and acts on the passing transaction
module ffa_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned OWNER_BITS = ffa_pkg::OWNER_BITS_DEF,
  parameter int unsigned CAP_W      = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  clr_i,
  input  logic [CAP_W-1:0]      cap_i,
  input  ffa_pkg::ffa_ctl_t     ctl_i,
  input  logic [OWNER_BITS-1:0] pid_i,
  input  logic [ffa_pkg::SEAT_W-1:0] seat_i,
  input  logic [OWNER_BITS-1:0] who_i,
  input  logic [CAP_W-1:0]      grant_i,
  output ffa_pkg::ffa_ctl_t     ctl_o,
  output logic [OWNER_BITS-1:0] pid_o,
  output logic [ffa_pkg::SEAT_W-1:0] seat_o,
  output logic [OWNER_BITS-1:0] who_o,
  output logic [CAP_W-1:0]      grant_o
);
  import ffa_pkg::*;

  localparam logic [CAP_W-1:0] MY_IDX  = CAP_W'(IDX);
  localparam logic [CAP_W-1:0] MY_SEAT = CAP_W'(IDX + 1);

  logic [OWNER_BITS-1:0] owner_q, owner_d;
  ffa_ctl_t              ctl_q, ctl_d;
  logic [OWNER_BITS-1:0] pid_q, who_q, who_d;
  logic [SEAT_W-1:0]     seat_q;
  logic [CAP_W-1:0]      grant_q, grant_d;
  logic                  hit;
  logic                  in_cap;

  assign hit    = (CAP_W'(seat_i) == MY_SEAT);
  assign in_cap = (MY_IDX < cap_i);

  // slot action for the transaction passing through
  always_comb begin
    owner_d = owner_q;
    ctl_d   = ctl_i;
    who_d   = who_i;
    grant_d = grant_i;
    if (ctl_i.valid && ctl_i.live) begin
      unique case (ctl_i.op)
        OP_RESERVE: begin
          if (!ctl_i.found && in_cap && owner_q == '0) begin
            owner_d     = pid_i;
            ctl_d.found = 1'b1;
            grant_d     = MY_SEAT;
          end
        end
        OP_RELEASE: begin
          if (hit && owner_q != '0) begin
            who_d       = owner_q;
            owner_d     = '0;
            ctl_d.found = 1'b1;
          end
        end
        OP_QUERY: begin
          if (hit) begin
            who_d = owner_q;
          end
        end
        OP_CLEAR: begin
          owner_d = '0;
        end
        default: begin
          owner_d = owner_q;
        end
      endcase
    end
  end

  // slot owner and stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q <= '0;
      ctl_q   <= '0;
    end else if (clr_i) begin
      owner_q <= '0;
      ctl_q   <= '0;
    end else if (adv_i) begin
      owner_q <= owner_d;
      ctl_q   <= ctl_d;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pid_q   <= pid_i;
      seat_q  <= seat_i;
      who_q   <= who_d;
      grant_q <= grant_d;
    end
  end

  assign ctl_o   = ctl_q;
  assign pid_o   = pid_q;
  assign seat_o  = seat_q;
  assign who_o   = who_q;
  assign grant_o = grant_q;

endmodule
